// ----- sv/atw_pkg.sv -----
package atw_pkg;

    localparam int unsigned SECTOR_W = 48;
    localparam int unsigned COUNT_W  = 17;
    localparam int unsigned DVD_W    = 32;   // CHS works on the low 32 sector bits
    localparam int unsigned SPT_W    = 8;
    localparam int unsigned HC_W     = 5;
    localparam int unsigned CYL_W    = 16;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned CNT_W    = 4;    // emit counter, up to nine writes
    localparam int unsigned DIV_STEPS = 4;   // quotient bits per divider stage

    localparam logic [MODE_W-1:0] MODE_CHS     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LBA28   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LBA48   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_SPT  = 2'd1;
    localparam logic [1:0] CFG_HC   = 2'd2;
    localparam logic [1:0] CFG_CYL  = 2'd3;

    localparam logic [IDX_W-1:0] REG_COUNT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOW    = 3'd1;
    localparam logic [IDX_W-1:0] REG_MID    = 3'd2;
    localparam logic [IDX_W-1:0] REG_HIGH   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DEVICE = 3'd4;

    localparam logic [7:0] DEV_LBA = 8'hE0;

    localparam logic [MODE_W-1:0] MODE_RST = MODE_CHS;
    localparam logic [SPT_W-1:0]  SPT_RST  = 8'd63;
    localparam logic [HC_W-1:0]   HC_RST   = 5'd16;
    localparam logic [CYL_W-1:0]  CYL_RST  = 16'd16383;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SPT_W-1:0]  spt;
        logic [HC_W-1:0]   hc;
        logic [CYL_W-1:0]  cyl;
    } cfg_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [COUNT_W-1:0]  count;
    } cmd_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [COUNT_W-1:0]  count;
        logic [SPT_W-1:0]    sect_rem;
    } cmd2_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [COUNT_W-1:0]  count;
        logic [SPT_W-1:0]    sect_rem;
        logic [DVD_W-1:0]    cyl;
        logic [HC_W-1:0]     head;
    } item_t;

endpackage

// ----- sv/atw_div.sv -----
module atw_div #(
    parameter int unsigned DIV_W  = 8,
    parameter int unsigned STEPS  = 4,
    parameter int unsigned SIDE_W = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [atw_pkg::DVD_W-1:0] in_dividend,
    input  logic [DIV_W-1:0]         divisor,
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic [atw_pkg::DVD_W-1:0] out_quot,
    output logic [DIV_W-1:0]         out_rem,
    output logic [SIDE_W-1:0]        out_side
);
    import atw_pkg::*;

    localparam int unsigned NST = DVD_W / STEPS;

    logic              v_reg    [NST];
    logic [DIV_W-1:0]  rem_reg  [NST];
    logic [DVD_W-1:0]  q_reg    [NST];
    logic [SIDE_W-1:0] side_reg [NST];

    // restoring division, STEPS quotient bits per stage; dividend bits shift
    // out of the top of q while quotient bits shift in at the bottom
    for (genvar g = 0; g < NST; g++) begin : g_st
        logic              v_in;
        logic [DIV_W-1:0]  r_in;
        logic [DVD_W-1:0]  q_in;
        logic [SIDE_W-1:0] s_in;
        logic [DIV_W-1:0]  r_next;
        logic [DVD_W-1:0]  q_next;
        logic [DIV_W:0]    t;

        if (g == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign q_in = in_dividend;
            assign s_in = in_side;
        end else begin : g_rest
            assign v_in = v_reg[g-1];
            assign r_in = rem_reg[g-1];
            assign q_in = q_reg[g-1];
            assign s_in = side_reg[g-1];
        end

        always_comb begin
            r_next = r_in;
            q_next = q_in;
            t      = '0;
            for (int i = 0; i < STEPS; i++) begin
                t      = {r_next, q_next[DVD_W-1]};
                q_next = {q_next[DVD_W-2:0], 1'b0};
                if (t >= {1'b0, divisor}) begin
                    t         = t - {1'b0, divisor};
                    q_next[0] = 1'b1;
                end
                r_next = t[DIV_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= v_in;
            end
            if (en) begin
                rem_reg[g]  <= r_next;
                q_reg[g]    <= q_next;
                side_reg[g] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_quot  = q_reg[NST-1];
    assign out_rem   = rem_reg[NST-1];
    assign out_side  = side_reg[NST-1];

endmodule

// ----- sv/atw_emit.sv -----
module atw_emit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  atw_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  atw_pkg::item_t              in_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [atw_pkg::IDX_W-1:0]   m_reg_index,
    output logic [7:0]                  m_reg_value,
    output logic                        m_error,
    output logic                        m_last
);
    import atw_pkg::*;

    logic             item_v_reg;
    item_t            item_reg;
    logic             err_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic             mv_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       val_reg;
    logic             merr_reg;
    logic             mlast_reg;

    logic             out_free;
    logic             fire;
    logic             in_err;
    logic [IDX_W-1:0] e_idx;
    logic [7:0]       e_val;
    logic             e_last;

    assign out_free = !mv_reg || m_ready;
    assign fire     = item_v_reg && out_free;
    assign in_ready = !item_v_reg || (fire && e_last);

    // error decided once when the item is taken
    assign in_err = (cfg.mode == MODE_INVALID) ||
                    ((cfg.mode == MODE_CHS) &&
                     ((cfg.spt == '0) || (cfg.hc == '0) ||
                      (in_item.cyl > {{(DVD_W-CYL_W){1'b0}}, cfg.cyl})));

    always_comb begin
        e_idx  = '0;
        e_val  = '0;
        e_last = 1'b1;
        if (!err_reg) begin
            case (cfg.mode)
                MODE_CHS: begin
                    e_last = (cnt_reg == CNT_W'(3));
                    case (cnt_reg[1:0])
                        2'd0: begin
                            e_idx = REG_LOW;
                            e_val = item_reg.sect_rem + 8'd1;
                        end
                        2'd1: begin
                            e_idx = REG_MID;
                            e_val = item_reg.cyl[7:0];
                        end
                        2'd2: begin
                            e_idx = REG_HIGH;
                            e_val = item_reg.cyl[15:8];
                        end
                        default: begin
                            e_idx = REG_DEVICE;
                            e_val = {{(8-HC_W){1'b0}}, item_reg.head};
                        end
                    endcase
                end
                MODE_LBA28: begin
                    e_last = (cnt_reg == CNT_W'(4));
                    case (cnt_reg[2:0])
                        3'd0: begin
                            e_idx = REG_COUNT;
                            e_val = item_reg.count[7:0];
                        end
                        3'd1: begin
                            e_idx = REG_LOW;
                            e_val = item_reg.sector[7:0];
                        end
                        3'd2: begin
                            e_idx = REG_MID;
                            e_val = item_reg.sector[15:8];
                        end
                        3'd3: begin
                            e_idx = REG_HIGH;
                            e_val = item_reg.sector[23:16];
                        end
                        default: begin
                            e_idx = REG_DEVICE;
                            e_val = DEV_LBA | {4'h0, item_reg.sector[27:24]};
                        end
                    endcase
                end
                default: begin  // LBA48: previous set, current set, device
                    e_last = (cnt_reg == CNT_W'(8));
                    case (cnt_reg)
                        CNT_W'(0): begin
                            e_idx = REG_COUNT;
                            e_val = item_reg.count[15:8];
                        end
                        CNT_W'(1): begin
                            e_idx = REG_LOW;
                            e_val = item_reg.sector[31:24];
                        end
                        CNT_W'(2): begin
                            e_idx = REG_MID;
                            e_val = item_reg.sector[39:32];
                        end
                        CNT_W'(3): begin
                            e_idx = REG_HIGH;
                            e_val = item_reg.sector[47:40];
                        end
                        CNT_W'(4): begin
                            e_idx = REG_COUNT;
                            e_val = item_reg.count[7:0];
                        end
                        CNT_W'(5): begin
                            e_idx = REG_LOW;
                            e_val = item_reg.sector[7:0];
                        end
                        CNT_W'(6): begin
                            e_idx = REG_MID;
                            e_val = item_reg.sector[15:8];
                        end
                        CNT_W'(7): begin
                            e_idx = REG_HIGH;
                            e_val = item_reg.sector[23:16];
                        end
                        default: begin
                            e_idx = REG_DEVICE;
                            e_val = DEV_LBA;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_v_reg <= 1'b0;
            cnt_reg    <= '0;
            mv_reg     <= 1'b0;
        end else begin
            if (fire) begin
                mv_reg  <= 1'b1;
                cnt_reg <= e_last ? '0 : cnt_reg + CNT_W'(1);
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            if (in_ready) begin
                item_v_reg <= in_valid;
            end
        end
        if (in_ready) begin
            item_reg <= in_item;
            err_reg  <= in_err;
        end
        if (fire) begin
            idx_reg   <= e_idx;
            val_reg   <= e_val;
            merr_reg  <= err_reg;
            mlast_reg <= e_last;
        end
    end

    assign m_valid     = mv_reg;
    assign m_reg_index = idx_reg;
    assign m_reg_value = val_reg;
    assign m_error     = merr_reg;
    assign m_last      = mlast_reg;

endmodule

// ----- sv/ata_taskfile_address_writer.sv -----
// Path: a request passes the spt and hc divider pipelines, the sequencer's item register
// and its output register. Throughput: one result per cycle while m_ready is high; a request
// yields 4 (CHS), 5 (LBA28), 9 (LBA48) or 1 (error) register writes, set by the result sequencer.
// Reset: synchronous, active-low aresetn clears all valid bits and loads
// the register reset values (CHS, 63 sectors, 16 heads, 16383 cylinders).
module ata_taskfile_address_writer #(
    parameter int unsigned DivStepsPerStage = atw_pkg::DIV_STEPS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [atw_pkg::SECTOR_W-1:0]   s_start_sector,
    input  logic [atw_pkg::COUNT_W-1:0]    s_sector_count,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [atw_pkg::IDX_W-1:0]      m_reg_index,
    output logic [7:0]                     m_reg_value,
    output logic                           m_error,
    output logic                           m_last
);
    import atw_pkg::*;

    cfg_t cfg_reg;

    logic        wr_en;
    logic [1:0]  rsel;

    logic        en;          // global pipeline advance
    cmd_t        cmd_in;

    logic              d1_valid;
    logic [DVD_W-1:0]  d1_quot;   // track
    logic [SPT_W-1:0]  d1_rem;    // sector within track, 0-based
    cmd_t              d1_side;
    cmd2_t             d2_side_in;

    logic              d2_valid;
    logic [DVD_W-1:0]  d2_quot;   // cylinder
    logic [HC_W-1:0]   d2_rem;    // head
    cmd2_t             d2_side;

    item_t             item;
    logic              emit_ready;

    // ---- register file ----
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign rsel   = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode <= MODE_RST;
            cfg_reg.spt  <= SPT_RST;
            cfg_reg.hc   <= HC_RST;
            cfg_reg.cyl  <= CYL_RST;
        end else if (wr_en) begin
            case (rsel)
                CFG_MODE: cfg_reg.mode <= pwdata[MODE_W-1:0];
                CFG_SPT:  cfg_reg.spt  <= pwdata[SPT_W-1:0];
                CFG_HC:   cfg_reg.hc   <= pwdata[HC_W-1:0];
                default:  cfg_reg.cyl  <= pwdata[CYL_W-1:0];
            endcase
        end
    end

    always_comb begin
        case (rsel)
            CFG_MODE: prdata = {{(32-MODE_W){1'b0}}, cfg_reg.mode};
            CFG_SPT:  prdata = {{(32-SPT_W){1'b0}}, cfg_reg.spt};
            CFG_HC:   prdata = {{(32-HC_W){1'b0}}, cfg_reg.hc};
            default:  prdata = {{(32-CYL_W){1'b0}}, cfg_reg.cyl};
        endcase
    end

    // ---- pipeline ----
    // Every stage moves together; it holds only when the last divider stage
    // has a request the sequencer cannot take. The user must keep config static
    // while requests are in flight (the block does not enforce it), so stages read it directly.
    assign en      = !d2_valid || emit_ready;
    assign s_ready = en;

    assign cmd_in.sector = s_start_sector;
    assign cmd_in.count  = s_sector_count;

    // sector / sectors-per-track
    atw_div #(
        .DIV_W  (SPT_W),
        .STEPS  (DivStepsPerStage),
        .SIDE_W ($bits(cmd_t))
    ) u_div_spt (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_valid),
        .in_dividend (s_start_sector[DVD_W-1:0]),
        .divisor     (cfg_reg.spt),
        .in_side     (cmd_in),
        .out_valid   (d1_valid),
        .out_quot    (d1_quot),
        .out_rem     (d1_rem),
        .out_side    (d1_side)
    );

    assign d2_side_in.sector   = d1_side.sector;
    assign d2_side_in.count    = d1_side.count;
    assign d2_side_in.sect_rem = d1_rem;

    // track / heads
    atw_div #(
        .DIV_W  (HC_W),
        .STEPS  (DivStepsPerStage),
        .SIDE_W ($bits(cmd2_t))
    ) u_div_hc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (d1_valid),
        .in_dividend (d1_quot),
        .divisor     (cfg_reg.hc),
        .in_side     (d2_side_in),
        .out_valid   (d2_valid),
        .out_quot    (d2_quot),
        .out_rem     (d2_rem),
        .out_side    (d2_side)
    );

    assign item.sector   = d2_side.sector;
    assign item.count    = d2_side.count;
    assign item.sect_rem = d2_side.sect_rem;
    assign item.cyl      = d2_quot;
    assign item.head     = d2_rem;

    // register-write sequencer with registered output
    atw_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (d2_valid),
        .in_ready    (emit_ready),
        .in_item     (item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_reg_index (m_reg_index),
        .m_reg_value (m_reg_value),
        .m_error     (m_error),
        .m_last      (m_last)
    );

endmodule
